FILE: hw/rtl/sflb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the switchable queue/stack record buffer
package sflb_pkg;

  // buffer capacity in records
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // payload widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned NAME_W   = 16;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned REC_W    = NAME_W + AGE_W;

  // opcodes; the remaining code is a no-op
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic load_now;  // result known at once, load output register
    logic load_mem;  // load output register from store read data
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read; // pending request reads a stored record
  } dp_status_t;

endpackage

FILE: hw/rtl/switchable_fifo_lifo_buffer_top.sv
`timescale 1ns / 1ps
// top level of the switchable queue/stack buffer of person records
//
// usage:
// - input channel (in_valid_i/in_ready_o) carries one request: opcode
//   (push, pop, peek; the fourth code is a no-op), a name handle and an age
// - output channel (out_valid_o/out_ready_i) returns one result per request:
//   name handle and age of the popped or peeked record, a status code
//   (ok, empty, full) and the record count after the request
// - cfg_we_i/cfg_wdata_i write the mode bit: 0 queue (oldest first),
//   1 stack (newest first); write it only while the buffer is idle
// - result path: push, no-op and empty/full requests deliver a result in the
//   cycle after acceptance; pop and peek that hit a record pass first through
//   the registered read port of the record store and then the result register
// - throughput: one request per cycle for push and no-op while the receiver
//   takes each result; pop and peek block new requests in the store read wait state
// - a new request is taken while the previous result is being handed off
// - when the receiver stalls, the result register holds and no new request
//   is taken until the result is taken
// - reset empties the buffer and selects queue mode; the store contents are
//   left as they are and no stale record is ever read back
module switchable_fifo_lifo_buffer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // mode register
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sflb_pkg::OP_W-1:0]     opcode_i,
  input  logic [sflb_pkg::NAME_W-1:0]   name_handle_i,
  input  logic [sflb_pkg::AGE_W-1:0]    age_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sflb_pkg::NAME_W-1:0]   out_name_handle_o,
  output logic [sflb_pkg::AGE_W-1:0]    out_age_o,
  output logic [sflb_pkg::STATUS_W-1:0] status_o,
  output logic [sflb_pkg::FILL_W-1:0]   fill_count_o
);
  import sflb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // handshake and sequencing
  sflb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // pointers, store and result register
  sflb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .opcode_i          (opcode_i),
    .name_handle_i     (name_handle_i),
    .age_i             (age_i),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .out_name_handle_o (out_name_handle_o),
    .out_age_o         (out_age_o),
    .out_status_o      (status_o),
    .out_fill_count_o  (fill_count_o)
  );

endmodule

FILE: hw/rtl/sflb_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module sflb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sflb_ctrl.sv
`timescale 1ns / 1ps
// handshake controller: request acceptance, read wait state, result valid
module sflb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sflb_pkg::dp_status_t status_i,
  output sflb_pkg::ctrl_cmd_t  cmd_o
);
  import sflb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  // output slot is free if empty or drained this cycle
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.load_now = accept && !status_i.need_read;
    cmd_o.load_mem = (state_q == S_READ);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && status_i.need_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_now || cmd_o.load_mem) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/sflb_dp.sv
`timescale 1ns / 1ps
// datapath: ring pointers, mode register, record store and result register
module sflb_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic [sflb_pkg::OP_W-1:0]        opcode_i,
  input  logic [sflb_pkg::NAME_W-1:0]      name_handle_i,
  input  logic [sflb_pkg::AGE_W-1:0]       age_i,
  input  sflb_pkg::ctrl_cmd_t              cmd_i,
  output sflb_pkg::dp_status_t             status_o,
  output logic [sflb_pkg::NAME_W-1:0]      out_name_handle_o,
  output logic [sflb_pkg::AGE_W-1:0]       out_age_o,
  output logic [sflb_pkg::STATUS_W-1:0]    out_status_o,
  output logic [sflb_pkg::FILL_W-1:0]      out_fill_count_o
);
  import sflb_pkg::*;

  logic                stack_mode_q;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                is_empty, is_full, is_pop, is_peek;
  logic [ADDR_W-1:0]   tail_addr, top_addr, rd_addr, head_inc;
  logic                ram_we, ram_re;
  logic [REC_W-1:0]    ram_rdata;
  logic [STATUS_W-1:0] now_status;
  logic [NAME_W-1:0]   name_q;
  logic [AGE_W-1:0]    age_q;
  logic [STATUS_W-1:0] status_q;
  logic [FILL_W-1:0]   fill_q;

  // (base + off) mod DEPTH, valid while base < DEPTH and off <= DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_pop   = (opcode_i == OP_POP);
  assign is_peek  = (opcode_i == OP_PEEK);

  assign tail_addr = wrap_add(head_q, count_q);
  assign top_addr  = wrap_add(head_q, count_q - CNT_W'(1));
  assign head_inc  = wrap_add(head_q, CNT_W'(1));
  assign rd_addr   = stack_mode_q ? top_addr : head_q;

  assign status_o.need_read = (is_pop || is_peek) && !is_empty;

  assign ram_we = cmd_i.accept && (opcode_i == OP_PUSH) && !is_full;
  assign ram_re = cmd_i.accept && status_o.need_read;

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    now_status = ST_OK;
    case (opcode_i)
      OP_PUSH: begin
        if (is_full) begin
          now_status = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          now_status = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
          if (!stack_mode_q) begin
            head_d = head_inc;
          end
        end
      end
      OP_PEEK: begin
        if (is_empty) begin
          now_status = ST_EMPTY;
        end
      end
      default: begin
        now_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_mode_q <= 1'b0;
      head_q       <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        stack_mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  sflb_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_addr),
    .wdata_i ({name_handle_i, age_i}),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // result register, count already updated when read data returns
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      name_q   <= '0;
      age_q    <= '0;
      status_q <= now_status;
      fill_q   <= FILL_W'(count_d);
    end else if (cmd_i.load_mem) begin
      name_q   <= ram_rdata[REC_W-1:AGE_W];
      age_q    <= ram_rdata[AGE_W-1:0];
      status_q <= ST_OK;
      fill_q   <= FILL_W'(count_q);
    end
  end

  assign out_name_handle_o = name_q;
  assign out_age_o         = age_q;
  assign out_status_o      = status_q;
  assign out_fill_count_o  = fill_q;

endmodule
